// ===== rtl/core/ccd_pkg.sv =====
// Console command decoder package: widths, codes, grammar tables.
// No dependencies.
package ccd_pkg;

    localparam int unsigned EngineerSlotsDef = 8;
    localparam int unsigned ArgBitsDef       = 16;
    localparam int unsigned NumArgs          = 5;
    localparam int unsigned NumForms         = 14;
    localparam int unsigned QueueDepth       = 2;

    localparam logic [3:0] CMD_SPEED    = 4'd0;
    localparam logic [3:0] CMD_REVERSE  = 4'd1;
    localparam logic [3:0] CMD_SWITCH   = 4'd2;
    localparam logic [3:0] CMD_HALT     = 4'd3;
    localparam logic [3:0] CMD_CREATE   = 4'd4;
    localparam logic [3:0] CMD_CAL_RUN  = 4'd5;
    localparam logic [3:0] CMD_CAL_WAIT = 4'd6;
    localparam logic [3:0] CMD_LOAD     = 4'd7;
    localparam logic [3:0] CMD_MARK     = 4'd8;
    localparam logic [3:0] CMD_GO       = 4'd9;
    localparam logic [3:0] CMD_QUIT     = 4'd10;
    localparam logic [3:0] CMD_TASKS    = 4'd11;
    localparam logic [3:0] CMD_TRACK    = 4'd12;
    localparam logic [3:0] CMD_TURNOUTS = 4'd13;
    localparam logic [3:0] CMD_HELP     = 4'd14;
    localparam logic [3:0] CMD_UNKNOWN  = 4'd15;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_BAD_ARG  = 3'd1;
    localparam logic [2:0] ST_FULL     = 3'd2;
    localparam logic [2:0] ST_ASSIGNED = 3'd3;
    localparam logic [2:0] ST_NO_ENG   = 3'd4;

    localparam logic [7:0] TK_END = 8'h00;
    localparam logic [7:0] TK_SP  = 8'h20;
    localparam logic [7:0] TK_NUM = 8'h4E;
    localparam logic [7:0] TK_GRP = 8'h47;
    localparam logic [7:0] TK_DIR = 8'h44;
    localparam logic [7:0] TK_TRK = 8'h54;
    localparam logic [7:0] CH_CR  = 8'h0D;

    localparam int unsigned PatLen  = 12;
    localparam int unsigned PatBits = 8 * PatLen;

    // one pattern token per position, null padded
    function automatic logic [7:0] pat_token(input logic [3:0] form, input logic [3:0] pos);
        logic [PatBits-1:0] p;
        logic [3:0]         n;
        logic [7:0]         t;
        unique case (form)
            4'd0:    begin p = PatBits'("tr N N");      n = 4'd6;  end
            4'd1:    begin p = PatBits'("rv N");        n = 4'd4;  end
            4'd2:    begin p = PatBits'("sw N D");      n = 4'd6;  end
            4'd3:    begin p = PatBits'("h N G N");     n = 4'd7;  end
            4'd4:    begin p = PatBits'("e N N");       n = 4'd5;  end
            4'd5:    begin p = PatBits'("c N N G N N"); n = 4'd11; end
            4'd6:    begin p = PatBits'("k T");         n = 4'd3;  end
            4'd7:    begin p = PatBits'("x N N");       n = 4'd5;  end
            4'd8:    begin p = PatBits'("go N N");      n = 4'd6;  end
            4'd9:    begin p = PatBits'("q");           n = 4'd1;  end
            4'd10:   begin p = PatBits'("d");           n = 4'd1;  end
            4'd11:   begin p = PatBits'("p");           n = 4'd1;  end
            4'd12:   begin p = PatBits'("o");           n = 4'd1;  end
            4'd13:   begin p = PatBits'("?");           n = 4'd1;  end
            default: begin p = '0;                      n = 4'd0;  end
        endcase
        if (pos < n)
            t = p[8 * (int'(n) - 1 - int'(pos)) +: 8];
        else
            t = TK_END;
        return t;
    endfunction

    function automatic logic [3:0] form_code(input logic [3:0] form);
        logic [3:0] c;
        unique case (form)
            4'd0:    c = CMD_SPEED;
            4'd1:    c = CMD_REVERSE;
            4'd2:    c = CMD_SWITCH;
            4'd3:    c = CMD_HALT;
            4'd4:    c = CMD_CREATE;
            4'd5:    c = CMD_CAL_RUN;
            4'd6:    c = CMD_LOAD;
            4'd7:    c = CMD_MARK;
            4'd8:    c = CMD_GO;
            4'd9:    c = CMD_QUIT;
            4'd10:   c = CMD_TASKS;
            4'd11:   c = CMD_TRACK;
            4'd12:   c = CMD_TURNOUTS;
            4'd13:   c = CMD_HELP;
            default: c = CMD_UNKNOWN;
        endcase
        return c;
    endfunction

    typedef struct packed {
        logic [3:0]  command;
        logic        in_range;
        logic [15:0] train_id;
        logic [15:0] value_a;
        logic [2:0]  group_code;
        logic [15:0] value_b;
        logic [15:0] loop_count;
        logic        switch_dir;
    } line_t;

    typedef struct packed {
        logic [3:0]  command;
        logic [2:0]  status;
        logic [15:0] train_id;
        logic [15:0] value_a;
        logic [2:0]  group_code;
        logic [15:0] value_b;
        logic [15:0] loop_count;
        logic        switch_dir;
        logic [3:0]  engineer_slot;
    } result_t;

endpackage

// ===== rtl/core/ccd_if.sv =====
// Valid/ready channel interfaces for the console command decoder.
// No dependencies.
interface ccd_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_in;
    modport source (output valid, output char_in, input ready);
    modport sink (input valid, input char_in, output ready);
endinterface

interface ccd_result_if;
    logic        valid;
    logic        ready;
    logic [3:0]  command;
    logic [2:0]  status;
    logic [15:0] train_id;
    logic [15:0] value_a;
    logic [2:0]  group_code;
    logic [15:0] value_b;
    logic [15:0] loop_count;
    logic        switch_dir;
    logic [3:0]  engineer_slot;
    modport source (output valid, output command, output status, output train_id,
        output value_a, output group_code, output value_b, output loop_count,
        output switch_dir, output engineer_slot, input ready);
    modport sink (input valid, input command, input status, input train_id,
        input value_a, input group_code, input value_b, input loop_count,
        input switch_dir, input engineer_slot, output ready);
endinterface

// ===== rtl/core/ccd_front.sv =====
// Front end: character folding, grammar tracking, argument collection, range checks.
// Depends on ccd_pkg.
module ccd_front
    import ccd_pkg::*;
#(
    parameter int unsigned ARG_BITS = ArgBitsDef
)
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   char_valid,
    output logic   char_ready,
    input  logic [7:0] char_in,
    output logic   line_valid,
    input  logic   line_ready,
    output line_t  line
);

    localparam logic [ARG_BITS-1:0] ArgMax = '1;
    localparam logic [ARG_BITS+3:0] ArgMaxW = {4'd0, ArgMax};

    logic                active_reg, active_next;
    logic                bad_reg, bad_next;
    logic                in_num_reg, in_num_next;
    logic [3:0]          form_reg, form_next;
    logic [3:0]          pos_reg, pos_next;
    logic [2:0]          idx_reg, idx_next;
    logic [ARG_BITS-1:0] arg_reg [NumArgs];
    logic [ARG_BITS-1:0] arg_next [NumArgs];
    logic [2:0]          grp_reg, grp_next;
    logic                dir_reg, dir_next;
    logic                halted_reg, halted_next;

    logic [7:0]          c;
    logic                take, printable, is_cr, digit, done;
    logic [7:0]          tok, tok1;
    logic [3:0]          dval;
    logic [ARG_BITS+3:0] prod;
    logic                found;
    logic [3:0]          found_form;
    logic [3:0]          code;
    logic [15:0]         a_clip [4];

    assign char_ready = !is_cr || line_ready || halted_reg;
    assign take       = char_valid && char_ready;

    always_comb
    begin
        c = char_in;
        if (c >= 8'h41 && c <= 8'h5A)
            c = c + 8'd32;
    end

    assign printable = (char_in >= 8'h20) && (char_in <= 8'h7E);
    assign is_cr     = (char_in == CH_CR);
    assign digit     = (c >= 8'h30) && (c <= 8'h39);
    assign dval      = 4'(c - 8'h30);
    assign tok       = pat_token(form_reg, pos_reg);
    assign tok1      = pat_token(form_reg, pos_reg + 4'd1);

    always_comb
    begin
        found      = 1'b0;
        found_form = '0;
        for (int i = NumForms - 1; i >= 0; i--)
        begin
            if (pat_token(4'(i), 4'd0) == c)
            begin
                found      = 1'b1;
                found_form = 4'(i);
            end
        end
    end

    always_comb
    begin
        logic [ARG_BITS+3:0] base;
        base = in_num_reg ? {4'd0, arg_reg[idx_reg]} : '0;
        prod = (base << 3) + (base << 1) + {{ARG_BITS{1'b0}}, dval};
    end

    always_comb
    begin
        active_next = active_reg;
        bad_next    = bad_reg;
        in_num_next = in_num_reg;
        form_next   = form_reg;
        pos_next    = pos_reg;
        idx_next    = idx_reg;
        arg_next    = arg_reg;
        grp_next    = grp_reg;
        dir_next    = dir_reg;
        halted_next = halted_reg;
        if (take && !halted_reg && printable && !bad_reg)
        begin
            if (!active_reg)
            begin
                if (found)
                begin
                    active_next = 1'b1;
                    form_next   = found_form;
                    pos_next    = 4'd1;
                    in_num_next = 1'b0;
                    idx_next    = '0;
                end
                else
                    bad_next = 1'b1;
            end
            else if (in_num_reg)
            begin
                if (digit)
                begin
                    if (idx_reg < 3'(NumArgs))
                        arg_next[idx_reg] = (prod > ArgMaxW) ? ArgMax : prod[ARG_BITS-1:0];
                end
                else if (tok1 == TK_SP && c == TK_SP)
                begin
                    pos_next    = pos_reg + 4'd2;
                    in_num_next = 1'b0;
                    idx_next    = idx_reg + 3'd1;
                end
                else
                    bad_next = 1'b1;
            end
            else
            begin
                priority case (1'b1)
                    tok == TK_END:
                        if (form_code(form_reg) < CMD_TRACK)
                            bad_next = 1'b1;
                    tok == TK_NUM:
                        if (digit)
                        begin
                            if (idx_reg < 3'(NumArgs))
                                arg_next[idx_reg] = prod[ARG_BITS-1:0];
                            in_num_next = 1'b1;
                        end
                        else
                            bad_next = 1'b1;
                    tok == TK_GRP:
                        if (c >= 8'h61 && c <= 8'h65)
                        begin
                            grp_next = 3'(c - 8'h61);
                            pos_next = pos_reg + 4'd1;
                        end
                        else
                            bad_next = 1'b1;
                    tok == TK_DIR:
                        if (c == 8'h63 || c == 8'h73)
                        begin
                            dir_next = (c == 8'h73);
                            pos_next = pos_reg + 4'd1;
                        end
                        else
                            bad_next = 1'b1;
                    tok == TK_TRK:
                        if (c == 8'h61 || c == 8'h62)
                        begin
                            dir_next = (c == 8'h62);
                            pos_next = pos_reg + 4'd1;
                        end
                        else
                            bad_next = 1'b1;
                    default:
                        if (c == tok)
                            pos_next = pos_reg + 4'd1;
                        else
                            bad_next = 1'b1;
                endcase
            end
        end
        else if (take && !halted_reg && is_cr)
        begin
            active_next = 1'b0;
            bad_next    = 1'b0;
            in_num_next = 1'b0;
            form_next   = '0;
            pos_next    = '0;
            idx_next    = '0;
            if (code == CMD_QUIT)
                halted_next = 1'b1;
        end
    end

    assign done = in_num_reg ? (tok1 == TK_END) : (tok == TK_END);

    always_comb
    begin
        code = CMD_UNKNOWN;
        if (active_reg && !bad_reg)
        begin
            if (done)
                code = form_code(form_reg);
            else if (form_reg == 4'd5 && pos_reg == 4'd1 && !in_num_reg)
                code = CMD_CAL_WAIT;
        end
    end

    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            if (ARG_BITS > 16)
                a_clip[i] = (arg_reg[i] > ARG_BITS'(16'hFFFF)) ? 16'hFFFF : 16'(arg_reg[i]);
            else
                a_clip[i] = 16'(arg_reg[i]);
        end
    end

    // arguments range checks use clipped values; clipped 65535 fails every bound
    always_comb
    begin
        logic [15:0] a0, a1, a2, a3;
        logic        tr_ok;
        a0 = a_clip[0];
        a1 = a_clip[1];
        a2 = a_clip[2];
        a3 = a_clip[3];
        tr_ok = (a0 >= 16'd1) && (a0 <= 16'd80);
        line = '0;
        line.command  = code;
        line.in_range = 1'b1;
        unique case (code)
            CMD_SPEED:
            begin
                line.train_id = a0;
                line.value_a  = a1;
                line.in_range = tr_ok && (a1 <= 16'd14);
            end
            CMD_REVERSE:
            begin
                line.train_id = a0;
                line.in_range = tr_ok;
            end
            CMD_SWITCH:
            begin
                line.value_a    = a0;
                line.switch_dir = dir_reg;
                line.in_range   = ((a0 >= 16'd1) && (a0 <= 16'd18))
                    || ((a0 >= 16'd153) && (a0 <= 16'd156));
            end
            CMD_HALT:
            begin
                line.train_id   = a0;
                line.group_code = grp_reg;
                line.value_b    = a1;
                line.in_range   = (a0 <= 16'd80) && (a1 >= 16'd1) && (a1 <= 16'd16);
            end
            CMD_CREATE:
            begin
                line.train_id = a0;
                line.value_a  = a1;
                line.in_range = tr_ok && (a1 < 16'd80);
            end
            CMD_CAL_RUN:
            begin
                line.train_id   = a0;
                line.value_a    = a1;
                line.group_code = grp_reg;
                line.value_b    = a2;
                line.loop_count = a3;
                line.in_range   = tr_ok && (a1 <= 16'd14) && (a2 >= 16'd1)
                    && (a2 <= 16'd16) && (a3 >= 16'd1) && (a3 <= 16'd20);
            end
            CMD_LOAD:
                line.switch_dir = dir_reg;
            CMD_MARK:
            begin
                line.train_id = a0;
                line.value_b  = a1;
                line.in_range = (a0 <= 16'd139) && (a1 <= 16'd875);
            end
            CMD_GO:
            begin
                line.train_id = a0;
                line.value_a  = a1;
                line.in_range = tr_ok && (a1 <= 16'd143);
            end
            default:
                line.in_range = 1'b1;
        endcase
    end

    assign line_valid = char_valid && is_cr && !halted_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            bad_reg    <= 1'b0;
            in_num_reg <= 1'b0;
            form_reg   <= '0;
            pos_reg    <= '0;
            idx_reg    <= '0;
            grp_reg    <= '0;
            dir_reg    <= 1'b0;
            halted_reg <= 1'b0;
            for (int i = 0; i < NumArgs; i++)
                arg_reg[i] <= '0;
        end
        else
        begin
            active_reg <= active_next;
            bad_reg    <= bad_next;
            in_num_reg <= in_num_next;
            form_reg   <= form_next;
            pos_reg    <= pos_next;
            idx_reg    <= idx_next;
            grp_reg    <= grp_next;
            dir_reg    <= dir_next;
            halted_reg <= halted_next;
            arg_reg    <= arg_next;
        end
    end

endmodule

// ===== rtl/core/ccd_queue.sv =====
// Two-entry line queue between decoder front and back.
// Depends on ccd_pkg.
module ccd_queue
    import ccd_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    output logic  in_ready,
    input  line_t in_line,
    output logic  out_valid,
    input  logic  out_ready,
    output line_t out_line
);

    line_t      mem_reg [QueueDepth];
    logic       wp_reg, rp_reg;
    logic [1:0] cnt_reg;
    logic       push, pop;

    assign in_ready  = (cnt_reg != 2'(QueueDepth));
    assign out_valid = (cnt_reg != 2'd0);
    assign out_line  = mem_reg[rp_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wp_reg] <= in_line;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
                wp_reg <= ~wp_reg;
            if (pop)
                rp_reg <= ~rp_reg;
            cnt_reg <= cnt_reg + 2'(push) - 2'(pop);
        end
    end

endmodule

// ===== rtl/core/ccd_back.sv =====
// Back end: engineer slot table search and insert, status, output register.
// Depends on ccd_pkg.
module ccd_back
    import ccd_pkg::*;
#(
    parameter int unsigned ENGINEER_SLOTS = EngineerSlotsDef
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    line_valid,
    output logic    line_ready,
    input  line_t   line,
    output logic    res_valid,
    input  logic    res_ready,
    output result_t res
);

    localparam int unsigned IdxW = (ENGINEER_SLOTS > 1) ? $clog2(ENGINEER_SLOTS) : 1;
    localparam int unsigned CntW = $clog2(ENGINEER_SLOTS + 1);

    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_SEARCH = 3'b010,
        S_OUT    = 3'b100
    } state_t;

    state_t          state_reg, state_next;
    logic [6:0]      slot_reg [ENGINEER_SLOTS];
    logic [CntW-1:0] count_reg;
    logic [CntW-1:0] scan_reg;
    logic            found_reg;
    logic [IdxW-1:0] hit_reg;
    line_t           cur_reg;
    result_t         res_reg;
    logic            res_valid_reg, res_valid_next;
    logic            tbl_cmd;
    logic            match;
    logic            load_out;
    logic [2:0]      out_status;
    logic [3:0]      out_slot;
    logic            do_insert;

    assign line_ready = (state_reg == S_IDLE);
    assign res_valid  = res_valid_reg;
    assign res        = res_reg;
    assign match      = (scan_reg < count_reg)
        && ({9'd0, slot_reg[scan_reg[IdxW-1:0]]} == cur_reg.train_id);
    assign tbl_cmd    = cur_reg.in_range && (cur_reg.command == CMD_SPEED
        || cur_reg.command == CMD_REVERSE || cur_reg.command == CMD_CREATE);
    assign load_out   = (state_reg == S_OUT) && (!res_valid_reg || res_ready);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
                if (line_valid)
                    state_next = S_SEARCH;
            S_SEARCH:
                if (!tbl_cmd || found_reg || match || scan_reg >= count_reg
                    || scan_reg == CntW'(ENGINEER_SLOTS - 1))
                    state_next = S_OUT;
            S_OUT:
                if (!res_valid_reg || res_ready)
                    state_next = S_IDLE;
            default:
                state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        res_valid_next = res_valid_reg;
        if (res_valid_reg && res_ready)
            res_valid_next = 1'b0;
        if (load_out)
            res_valid_next = 1'b1;
    end

    always_comb
    begin
        out_status = ST_OK;
        out_slot   = 4'hF;
        do_insert  = 1'b0;
        if (!cur_reg.in_range)
            out_status = ST_BAD_ARG;
        else
        begin
            unique case (cur_reg.command)
                CMD_SPEED, CMD_REVERSE:
                    if (found_reg)
                        out_slot = 4'(hit_reg);
                CMD_CREATE:
                    if (count_reg >= CntW'(ENGINEER_SLOTS))
                        out_status = ST_FULL;
                    else if (found_reg)
                    begin
                        out_status = ST_ASSIGNED;
                        out_slot   = 4'(hit_reg);
                    end
                    else
                    begin
                        do_insert = 1'b1;
                        out_slot  = 4'(count_reg);
                    end
                CMD_MARK:
                    if (count_reg == '0)
                        out_status = ST_NO_ENG;
                    else
                        out_slot = 4'd0;
                default:
                    out_status = ST_OK;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            scan_reg      <= '0;
            found_reg     <= 1'b0;
            hit_reg       <= '0;
            cur_reg       <= '0;
            res_reg       <= '0;
            res_valid_reg <= 1'b0;
            for (int i = 0; i < ENGINEER_SLOTS; i++)
                slot_reg[i] <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            res_valid_reg <= res_valid_next;
            if (state_reg == S_IDLE && line_valid)
            begin
                cur_reg   <= line;
                scan_reg  <= '0;
                found_reg <= 1'b0;
            end
            if (state_reg == S_SEARCH)
            begin
                if (match && !found_reg)
                begin
                    found_reg <= 1'b1;
                    hit_reg   <= scan_reg[IdxW-1:0];
                end
                if (!found_reg && !match && scan_reg < count_reg)
                    scan_reg <= scan_reg + CntW'(1);
            end
            if (load_out)
            begin
                res_reg.command       <= cur_reg.command;
                res_reg.status        <= out_status;
                res_reg.train_id      <= cur_reg.train_id;
                res_reg.value_a       <= cur_reg.value_a;
                res_reg.group_code    <= cur_reg.group_code;
                res_reg.value_b       <= cur_reg.value_b;
                res_reg.loop_count    <= cur_reg.loop_count;
                res_reg.switch_dir    <= cur_reg.switch_dir;
                res_reg.engineer_slot <= out_slot;
                if (do_insert)
                begin
                    slot_reg[count_reg[IdxW-1:0]] <= cur_reg.train_id[6:0];
                    count_reg <= count_reg + CntW'(1);
                end
            end
        end
    end

endmodule

// ===== rtl/core/console_command_decoder_unit.sv =====
// Console command decoder top level: front, line queue, back.
// Depends on ccd_pkg, ccd_if, ccd_front, ccd_queue, ccd_back.
// Path: a carriage return pushes the line into the queue; the back end takes it
// in S_IDLE, walks the slot table in S_SEARCH and registers the result in S_OUT.
// Throughput: printable characters one per cycle; the back end takes a new line
// only in S_IDLE, once the slot search and result of the last line are done.
// Reset: asynchronous, clears grammar state, arguments, slot table and quit flag.
module console_command_decoder_unit
    import ccd_pkg::*;
#(
    parameter int unsigned ENGINEER_SLOTS = EngineerSlotsDef,
    parameter int unsigned ARG_BITS       = ArgBitsDef
)
(
    input logic          clk,
    input logic          rst_n,
    ccd_char_if.sink     char_ch,
    ccd_result_if.source result_ch
);

    logic    fl_valid, fl_ready, ql_valid, ql_ready;
    line_t   fl_line, ql_line;
    result_t res;

    ccd_front #(.ARG_BITS(ARG_BITS)) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .char_valid (char_ch.valid),
        .char_ready (char_ch.ready),
        .char_in    (char_ch.char_in),
        .line_valid (fl_valid),
        .line_ready (fl_ready),
        .line       (fl_line)
    );

    ccd_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (fl_valid),
        .in_ready  (fl_ready),
        .in_line   (fl_line),
        .out_valid (ql_valid),
        .out_ready (ql_ready),
        .out_line  (ql_line)
    );

    ccd_back #(.ENGINEER_SLOTS(ENGINEER_SLOTS)) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .line_valid (ql_valid),
        .line_ready (ql_ready),
        .line       (ql_line),
        .res_valid  (result_ch.valid),
        .res_ready  (result_ch.ready),
        .res        (res)
    );

    assign result_ch.command       = res.command;
    assign result_ch.status        = res.status;
    assign result_ch.train_id      = res.train_id;
    assign result_ch.value_a       = res.value_a;
    assign result_ch.group_code    = res.group_code;
    assign result_ch.value_b       = res.value_b;
    assign result_ch.loop_count    = res.loop_count;
    assign result_ch.switch_dir    = res.switch_dir;
    assign result_ch.engineer_slot = res.engineer_slot;

endmodule
